// ===== hdl/lse_pkg.sv =====
// ----------------------------------------------------------------------------
// lse_pkg
// Shared types and constants for the LSB hidden-message extractor.
// ----------------------------------------------------------------------------
`default_nettype none

package lse_pkg;

    // Message framing
    localparam int LEN_BYTES = 4;
    localparam int EXT_MAX   = 15;
    localparam int CNT_W     = 32;
    localparam int SEEN_W    = $clog2(LEN_BYTES + 1);
    localparam int EXT_W     = $clog2(EXT_MAX + 1);

    // Extraction phases
    localparam logic [1:0] PH_LEN  = 2'd0;
    localparam logic [1:0] PH_PAY  = 2'd1;
    localparam logic [1:0] PH_EXT  = 2'd2;
    localparam logic [1:0] PH_DONE = 2'd3;

    // Result kinds
    localparam logic [1:0] KIND_LEN = 2'd0;
    localparam logic [1:0] KIND_PAY = 2'd1;
    localparam logic [1:0] KIND_EXT = 2'd2;

    // Configuration register indexes
    localparam logic REG_MODE       = 1'b0;
    localparam logic REG_EXT_FOLLOW = 1'b1;

    // Gathering modes
    localparam logic MODE_LSB1 = 1'b0;
    localparam logic MODE_LSB4 = 1'b1;

    typedef struct packed {
        logic [7:0] carrier_byte;
        logic       first;
    } in_item_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [1:0] kind;
        logic       last;
    } out_item_t;

    typedef struct packed {
        logic      valid;
        out_item_t item;
    } step_res_t;

endpackage

`default_nettype wire

// ===== hdl/lse_in_stage.sv =====
// ----------------------------------------------------------------------------
// lse_in_stage
// Input register: holds one carrier word until the core takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module lse_in_stage
    import lse_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_stall,
    input  in_item_t      in_data,
    input  wire logic     advance,
    output logic          s1_valid,
    output in_item_t      s1_item
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    // Stall only when a held word cannot move on
    assign in_stall   = valid_reg && !advance;
    assign valid_next = in_stall ? valid_reg : in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture payload on accept
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            item_reg <= in_data;
        end
    end

    assign s1_valid = valid_reg;
    assign s1_item  = item_reg;

endmodule

`default_nettype wire

// ===== hdl/lse_core.sv =====
// ----------------------------------------------------------------------------
// lse_core
// Extraction state and per-word step logic: gathers low bits or nibbles into
// hidden bytes and tracks length, payload and extension phases.
// ----------------------------------------------------------------------------
`default_nettype none

module lse_core
    import lse_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     cfg_we,
    input  wire logic     cfg_index,
    input  wire logic     cfg_data,
    input  wire logic     s1_valid,
    input  in_item_t      s1_item,
    input  wire logic     advance,
    output step_res_t     res
);

    logic              mode_reg;
    logic              ext_follow_reg;
    logic [1:0]        phase_reg,  phase_next;
    logic [2:0]        bitpos_reg, bitpos_next;
    logic [7:0]        asm_reg,    asm_next;
    logic [SEEN_W-1:0] seen_reg,   seen_next;
    logic [CNT_W-1:0]  rem_reg,    rem_next;
    logic [EXT_W-1:0]  extcnt_reg, extcnt_next;

    logic              fire;
    logic [1:0]        cur_phase;
    logic [2:0]        cur_bitpos;
    logic [7:0]        cur_asm;
    logic [SEEN_W-1:0] cur_seen;
    logic [CNT_W-1:0]  cur_rem;
    logic [EXT_W-1:0]  cur_extcnt;
    logic [7:0]        shifted;
    logic [3:0]        gathered;
    logic [SEEN_W-1:0] seen_inc;
    logic [CNT_W-1:0]  rem_shift;
    logic [CNT_W-1:0]  rem_dec;
    logic [EXT_W-1:0]  ext_inc;

    assign fire = s1_valid && advance;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_LSB1;
            ext_follow_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_MODE)
            begin
                mode_reg <= cfg_data;
            end
            if (cfg_index == REG_EXT_FOLLOW)
            begin
                ext_follow_reg <= cfg_data;
            end
        end
    end

    // Apply restart on a first-marked word
    always_comb
    begin
        if (s1_item.first)
        begin
            cur_phase  = PH_LEN;
            cur_bitpos = '0;
            cur_asm    = '0;
            cur_seen   = '0;
            cur_rem    = '0;
            cur_extcnt = '0;
        end
        else
        begin
            cur_phase  = phase_reg;
            cur_bitpos = bitpos_reg;
            cur_asm    = asm_reg;
            cur_seen   = seen_reg;
            cur_rem    = rem_reg;
            cur_extcnt = extcnt_reg;
        end
    end

    // Shift in the low bit or low nibble
    always_comb
    begin
        if (mode_reg == MODE_LSB4)
        begin
            shifted  = {cur_asm[3:0], s1_item.carrier_byte[3:0]};
            gathered = {1'b0, cur_bitpos} + 4'd4;
        end
        else
        begin
            shifted  = {cur_asm[6:0], s1_item.carrier_byte[0]};
            gathered = {1'b0, cur_bitpos} + 4'd1;
        end
    end

    assign seen_inc  = cur_seen + SEEN_W'(1);
    assign rem_shift = {cur_rem[CNT_W-9:0], shifted};
    assign rem_dec   = cur_rem - CNT_W'(1);
    assign ext_inc   = cur_extcnt + EXT_W'(1);

    // Step: next state and result
    always_comb
    begin
        phase_next         = cur_phase;
        bitpos_next        = cur_bitpos;
        asm_next           = cur_asm;
        seen_next          = cur_seen;
        rem_next           = cur_rem;
        extcnt_next        = cur_extcnt;
        res.valid          = 1'b0;
        res.item.data_byte = shifted;
        res.item.kind      = KIND_LEN;
        res.item.last      = 1'b0;

        if (cur_phase != PH_DONE)
        begin
            if (!gathered[3])
            begin
                bitpos_next = gathered[2:0];
                asm_next    = shifted;
            end
            else
            begin
                bitpos_next = '0;
                asm_next    = '0;
                res.valid   = s1_valid;
                case (cur_phase)
                    PH_LEN:
                    begin
                        res.item.kind = KIND_LEN;
                        rem_next      = rem_shift;
                        seen_next     = seen_inc;
                        if (seen_inc >= SEEN_W'(LEN_BYTES))
                        begin
                            if (rem_shift != '0)
                            begin
                                phase_next = PH_PAY;
                            end
                            else if (ext_follow_reg)
                            begin
                                phase_next = PH_EXT;
                            end
                            else
                            begin
                                phase_next    = PH_DONE;
                                res.item.last = 1'b1;
                            end
                        end
                    end
                    PH_PAY:
                    begin
                        res.item.kind = KIND_PAY;
                        rem_next      = rem_dec;
                        if (rem_dec == '0)
                        begin
                            if (ext_follow_reg)
                            begin
                                phase_next = PH_EXT;
                            end
                            else
                            begin
                                phase_next    = PH_DONE;
                                res.item.last = 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        res.item.kind = KIND_EXT;
                        extcnt_next   = ext_inc;
                        if (shifted == 8'h00 || ext_inc >= EXT_W'(EXT_MAX))
                        begin
                            phase_next    = PH_DONE;
                            res.item.last = 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    // Advance state on each consumed word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_LEN;
            bitpos_reg <= '0;
            asm_reg    <= '0;
            seen_reg   <= '0;
            rem_reg    <= '0;
            extcnt_reg <= '0;
        end
        else if (fire)
        begin
            phase_reg  <= phase_next;
            bitpos_reg <= bitpos_next;
            asm_reg    <= asm_next;
            seen_reg   <= seen_next;
            rem_reg    <= rem_next;
            extcnt_reg <= extcnt_next;
        end
    end

    // A final byte leaves the extractor finished
    a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res.valid && res.item.last |=> phase_reg == PH_DONE)
        else $error("last byte did not finish the message");

    // Payload phase always has bytes left
    a_pay_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PAY |-> rem_reg != '0)
        else $error("payload phase with zero remaining count");

    // Extension count stays below its limit while open
    a_ext_bound: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_EXT |-> extcnt_reg < EXT_W'(EXT_MAX))
        else $error("extension count reached limit without finishing");

endmodule

`default_nettype wire

// ===== hdl/lse_out_stage.sv =====
// ----------------------------------------------------------------------------
// lse_out_stage
// Result register: holds one hidden byte until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module lse_out_stage
    import lse_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  step_res_t     res,
    output logic          advance,
    output logic          out_valid,
    input  wire logic     out_stall,
    output out_item_t     out_data
);

    logic      valid_reg;
    logic      valid_next;
    out_item_t item_reg;

    // Move on when the register is empty or being drained
    assign advance    = !valid_reg || !out_stall;
    assign valid_next = advance ? res.valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Load a new result
    always_ff @(posedge clk)
    begin
        if (advance && res.valid)
        begin
            item_reg <= res.item;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = item_reg;

endmodule

`default_nettype wire

// ===== hdl/lsb_stego_extractor.sv =====
// ----------------------------------------------------------------------------
// lsb_stego_extractor
// Recovers a message hidden in the low bits of carrier image bytes.
//
// Input channel (in_valid / in_stall / in_data): one carrier byte after the
// image header per word; in_data.first restarts extraction at the length
// field. Output channel (out_valid / out_stall / out_data): one hidden byte
// per word, tagged as length, payload or extension byte, with last set on
// the final byte of the message. Carrier words after the final byte give no
// output until first is seen again.
// Configuration (cfg_we / cfg_index / cfg_data): index 0 selects one low bit
// (0) or the low nibble (1) per carrier byte; index 1 enables the
// null-terminated extension. Write only while the block is idle.
// An accepted word is held in the input register, and the hidden byte it
// completes, if any, lands in the result register for the receiver to take.
// One word is accepted per cycle while in_stall is low; the single step of
// state logic between the input and result registers sets that rate.
// Reset clears all state to the length-field phase, mode to one bit per
// byte and the extension flag to 1. When the receiver stalls, the result
// register holds, then the input register fills and in_stall rises.
// ----------------------------------------------------------------------------
`default_nettype none

module lsb_stego_extractor
    import lse_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     cfg_we,
    input  wire logic     cfg_index,
    input  wire logic     cfg_data,
    input  wire logic     in_valid,
    output logic          in_stall,
    input  in_item_t      in_data,
    output logic          out_valid,
    input  wire logic     out_stall,
    output out_item_t     out_data
);

    logic      advance;
    logic      s1_valid;
    in_item_t  s1_item;
    step_res_t res;

    lse_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .advance  (advance),
        .s1_valid (s1_valid),
        .s1_item  (s1_item)
    );

    lse_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s1_valid  (s1_valid),
        .s1_item   (s1_item),
        .advance   (advance),
        .res       (res)
    );

    lse_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .res       (res),
        .advance   (advance),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire
